[hw/rtl/tts_pkg.sv]
// ============================================================================
// Truncated Taylor sine package
// Widths, fixed-point constants and the per-term divisor table shared by the
// series sequencer and its digit-serial divider.
// ============================================================================
package tts_pkg;

    // Field widths of the channels.
    localparam int ANGLE_W = 32;
    localparam int CNT_W   = 4;
    localparam int OUT_W   = 48;

    // Series configuration.
    localparam int MAX_TERMS = 10;
    localparam int FRAC_BITS = 28;

    // Shared multiplier and the limbs that feed it.
    localparam int LIMB_W = 32;
    localparam int OPND_W = 2 * LIMB_W;
    localparam int PROD_W = 2 * OPND_W;

    // Accumulator and term magnitudes; a term is capped at 2^(ACC_W-2).
    localparam int ACC_W  = 64;
    localparam int TERM_W = ACC_W - 1;

    // The magnitude is at most 2^(ANGLE_W-1), so its square fits 2*ANGLE_W-1 bits.
    localparam int SQ_W = 2 * ANGLE_W - 1 - FRAC_BITS;

    // Digit-serial divider: DIV_DIGITS quotient bits per cycle.
    localparam int DIV_DIGITS = 8;
    localparam int DIV_CYCLES = (TERM_W + DIV_DIGITS - 1) / DIV_DIGITS;
    localparam int DIVD_W     = DIV_CYCLES * DIV_DIGITS;
    localparam int DIVR_W     = $clog2(2 * (MAX_TERMS - 1) * (2 * MAX_TERMS - 1) + 1);
    localparam int DCNT_W     = $clog2(DIV_CYCLES);

    typedef logic [DIVD_W-1:0] t_dividend;
    typedef logic [DIVR_W-1:0] t_divisor;

    // Divisor that turns term k-1 into term k: (2k)(2k+1).
    function automatic t_divisor term_divisor(input logic [CNT_W-1:0] k);
        logic [CNT_W:0] m;
        logic [2*CNT_W+1:0] p;
        m = {k, 1'b0};
        p = m * (m + 1'b1);
        return p[DIVR_W-1:0];
    endfunction

endpackage

[hw/rtl/tts_divider.sv]
// ============================================================================
// Truncated Taylor sine divider
// Digit-serial restoring divider by a narrow divisor. Each cycle retires
// DIV_DIGITS quotient bits, most significant first; the quotient shifts in
// where the dividend shifts out.
// ============================================================================
module tts_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  tts_pkg::t_dividend i_dividend,
    input  tts_pkg::t_divisor  i_divisor,
    output tts_pkg::t_dividend o_quotient,
    output logic               o_done
);
    import tts_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    t_dividend         r_shift;
    t_divisor          r_rem;
    t_divisor          r_divisor;

    t_dividend         n_shift;
    t_divisor          n_rem;
    logic [DIVR_W:0]   w_trial;

    always_comb begin
        n_shift = r_shift;
        n_rem   = r_rem;
        w_trial = '0;
        for (int i = 0; i < DIV_DIGITS; i++) begin
            w_trial = {n_rem, n_shift[DIVD_W-1]};
            n_shift = {n_shift[DIVD_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_divisor}) begin
                w_trial    = w_trial - {1'b0, r_divisor};
                n_shift[0] = 1'b1;
            end
            n_rem = w_trial[DIVR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_busy    <= 1'b1;
                r_cnt     <= '0;
                r_shift   <= i_dividend;
                r_rem     <= '0;
                r_divisor <= i_divisor;
            end else if (r_busy) begin
                r_shift <= n_shift;
                r_rem   <= n_rem;
                r_cnt   <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_shift;
    assign o_done     = r_done;

    // A new division never starts on top of one in flight.
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !r_busy)
        else $error("divider loaded while busy");

    // The partial remainder always stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_divisor))
        else $error("divider remainder out of range");

    // Completion follows the last digit cycle.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("divider done without a finished run");

endmodule

[hw/rtl/truncated_taylor_sine.sv]
// ============================================================================
// Truncated Taylor sine
// Sums the first n terms of the sine power series of a fixed-point angle
// with one shared 32x32 multiplier and a digit-serial divider.
// ============================================================================
// Usage:
//   Raise start with i_angle (signed Q3.28) and i_term_count; the beat is
//   taken at a clock edge where start is high and busy is low. busy stays
//   high until the sum is done. The result appears on o_sine_value (signed
//   Q19.28) and o_saturated for exactly one cycle, marked by o_valid; the
//   receiver cannot stall it, so it must take the beat in that cycle.
// Sequence:
//   Each term after the first runs four limb products on the shared
//   multiplier, one overflow check and the divider (eight quotient bits
//   per cycle over 64 bits); a product out of range skips the divider.
//   The block takes no new item while a sum is in progress: busy is low
//   in the cycle that o_valid is high, so the next item can be taken
//   there. A term count above ten is treated as ten.
// Reset: synchronous, active low; clears the sequencer and drops o_valid.
// ============================================================================
module truncated_taylor_sine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [tts_pkg::ANGLE_W-1:0]  i_angle,
    input  logic        [tts_pkg::CNT_W-1:0]    i_term_count,
    output logic                                o_valid,
    output logic signed [tts_pkg::OUT_W-1:0]    o_sine_value,
    output logic                                o_saturated
);
    import tts_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQR  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    localparam logic [TERM_W-1:0] TERM_CAP = {1'b1, {(TERM_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ACC_CAP = {2'b01, {(ACC_W-2){1'b0}}};
    localparam logic signed [ACC_W-1:0] NEG_CAP = {2'b11, {(ACC_W-2){1'b0}}};
    localparam logic signed [ACC_W-1:0] OUT_MAX =
        {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] OUT_MIN =
        {{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    logic [2:0]               r_state;
    logic                     r_valid;
    logic                     r_neg;
    logic [ANGLE_W-1:0]       r_mag;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         r_k;
    logic [SQ_W-1:0]          r_sq;
    logic [TERM_W-1:0]        r_term;
    logic [1:0]               r_pp;
    logic [PROD_W-1:0]        r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_sticky;
    logic signed [OUT_W-1:0]  r_sine;
    logic                     r_sat;

    logic [CNT_W-1:0]         w_cnt_in;
    logic [ANGLE_W-1:0]       w_mag_in;
    logic [OPND_W-1:0]        w_term_ext;
    logic [OPND_W-1:0]        w_sq_ext;
    logic [LIMB_W-1:0]        w_mul_a;
    logic [LIMB_W-1:0]        w_mul_b;
    logic [OPND_W-1:0]        w_mul_p;
    logic [PROD_W-1:0]        w_pp;
    logic [PROD_W-1:0]        n_prod;
    logic                     w_ovf;
    logic                     w_tneg;
    logic                     w_last;
    logic signed [ACC_W-1:0]  w_mag_s;
    logic signed [ACC_W-1:0]  w_quot_s;
    logic signed [ACC_W-1:0]  w_sum;
    logic                     w_sat;
    logic                     w_div_load;
    logic                     w_div_done;
    t_dividend                w_quot;

    assign w_cnt_in = (i_term_count > CNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
                                                          : i_term_count;
    assign w_mag_in = i_angle[ANGLE_W-1] ? (~i_angle + 1'b1) : i_angle;

    // Shared multiplier: squares the magnitude once, then forms the four limb
    // products of term times square.
    assign w_term_ext = OPND_W'(r_term);
    assign w_sq_ext   = OPND_W'(r_sq);

    always_comb begin
        if (r_state == ST_SQR) begin
            w_mul_a = r_mag;
            w_mul_b = r_mag;
        end else begin
            w_mul_a = r_pp[1] ? w_term_ext[OPND_W-1:LIMB_W] : w_term_ext[LIMB_W-1:0];
            w_mul_b = r_pp[0] ? w_sq_ext[OPND_W-1:LIMB_W] : w_sq_ext[LIMB_W-1:0];
        end
    end

    assign w_mul_p = OPND_W'(w_mul_a) * OPND_W'(w_mul_b);

    always_comb begin
        case (r_pp) inside
            2'd0:       w_pp = PROD_W'(w_mul_p);
            2'd1, 2'd2: w_pp = PROD_W'(w_mul_p) << LIMB_W;
            default:    w_pp = PROD_W'(w_mul_p) << (2 * LIMB_W);
        endcase
    end

    assign n_prod = r_prod + w_pp;
    assign w_ovf  = |r_prod[PROD_W-1:TERM_W+FRAC_BITS];
    assign w_tneg = r_neg ^ r_k[0];
    assign w_last = (r_k == (r_cnt - CNT_W'(1)));

    assign w_mag_s  = ACC_W'(r_mag);
    assign w_quot_s = {1'b0, w_quot[TERM_W-1:0]};
    assign w_sum    = w_tneg ? (r_acc - w_quot_s) : (r_acc + w_quot_s);
    assign w_sat    = r_sticky || (r_acc > OUT_MAX) || (r_acc < OUT_MIN);

    assign w_div_load = (r_state == ST_CHK) && !w_ovf;

    tts_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_div_load),
        .i_dividend (DIVD_W'(r_prod[TERM_W+FRAC_BITS-1:FRAC_BITS])),
        .i_divisor  (term_divisor(r_k)),
        .o_quotient (w_quot),
        .o_done     (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_neg    <= i_angle[ANGLE_W-1];
                        r_mag    <= w_mag_in;
                        r_cnt    <= w_cnt_in;
                        r_acc    <= '0;
                        r_sticky <= 1'b0;
                        r_state  <= (w_cnt_in == '0) ? ST_FIN : ST_SQR;
                    end
                end
                ST_SQR: begin
                    r_sq    <= w_mul_p[SQ_W+FRAC_BITS-1:FRAC_BITS];
                    r_term  <= TERM_W'(r_mag);
                    r_acc   <= r_neg ? -w_mag_s : w_mag_s;
                    r_k     <= CNT_W'(1);
                    r_pp    <= '0;
                    r_prod  <= '0;
                    r_state <= (r_cnt == CNT_W'(1)) ? ST_FIN : ST_MUL;
                end
                ST_MUL: begin
                    r_prod <= n_prod;
                    r_pp   <= r_pp + 1'b1;
                    if (r_pp == 2'd3) begin
                        r_state <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    if (w_ovf) begin
                        // A product beyond range pins the term and the sum.
                        r_term   <= TERM_CAP;
                        r_acc    <= w_tneg ? NEG_CAP : ACC_CAP;
                        r_sticky <= 1'b1;
                        r_pp     <= '0;
                        r_prod   <= '0;
                        r_k      <= r_k + 1'b1;
                        r_state  <= w_last ? ST_FIN : ST_MUL;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        if (w_quot[TERM_W-1]) begin
                            // A quotient at or above the cap pins the term and the sum.
                            r_term   <= TERM_CAP;
                            r_acc    <= w_tneg ? NEG_CAP : ACC_CAP;
                            r_sticky <= 1'b1;
                        end else begin
                            r_term <= w_quot[TERM_W-1:0];
                            if (w_sum > ACC_CAP) begin
                                r_acc    <= ACC_CAP;
                                r_sticky <= 1'b1;
                            end else if (w_sum < NEG_CAP) begin
                                r_acc    <= NEG_CAP;
                                r_sticky <= 1'b1;
                            end else begin
                                r_acc <= w_sum;
                            end
                        end
                        r_pp    <= '0;
                        r_prod  <= '0;
                        r_k     <= r_k + 1'b1;
                        r_state <= w_last ? ST_FIN : ST_MUL;
                    end
                end
                ST_FIN: begin
                    r_sat   <= w_sat;
                    r_sine  <= w_sat ? ((r_acc >= 0) ? OUT_MAX[OUT_W-1:0] : OUT_MIN[OUT_W-1:0])
                                     : r_acc[OUT_W-1:0];
                    r_valid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_valid;
    assign o_sine_value = r_sine;
    assign o_saturated  = r_sat;

    // The result strobe lasts exactly one cycle.
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // An accepted beat starts the square or, for an empty sum, finishes.
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ((r_state == ST_SQR) || (r_state == ST_FIN)))
        else $error("accepted beat did not start the series");

    // While a sum is in progress the clamped accumulator stays within the term cap.
    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> ((r_acc <= ACC_CAP) && (r_acc >= NEG_CAP)))
        else $error("accumulator beyond its clamp");

    // The divider only finishes while the sequencer waits for it.
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// Truncated Taylor sine testbench
// Sends angle and term-count beats through the start/busy handshake and
// computes the expected truncated series sum for each accepted beat. Every
// result strobe is compared field by field with the oldest pending sum.
// Directed beats cover the angle extremes, zero and clamped term counts,
// followed by randomized beats, with random sender gaps outside a back-to-back stretch.
// ============================================================================
module tb_top;
    import tts_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 160;
    localparam int RANDOM_BEATS   = 1000;

    localparam logic signed [63:0] TERM_CAP = 64'sh4000_0000_0000_0000;
    localparam logic signed [63:0] SINE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] SINE_MIN = -SINE_MAX - 64'sd1;

    localparam logic [ANGLE_W-1:0] ANGLE_HALF_PI = 32'd421657428;

    typedef struct packed {
        logic signed [OUT_W-1:0] sine;
        logic                    sat;
    } t_sine_result;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic signed [ANGLE_W-1:0] i_angle;
    logic        [CNT_W-1:0]   i_term_count;
    logic                      o_valid;
    logic signed [OUT_W-1:0]   o_sine_value;
    logic                      o_saturated;

    t_sine_result pending_sines[$];
    int           fail_count;
    int           stall_cycles;
    bit           gaps_enabled;

    truncated_taylor_sine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_angle      (i_angle),
        .i_term_count (i_term_count),
        .o_valid      (o_valid),
        .o_sine_value (o_sine_value),
        .o_saturated  (o_saturated)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Series sum built term from term, each step truncated in magnitude.
    function automatic t_sine_result series_sum(input logic [ANGLE_W-1:0] angle,
                                                input logic [CNT_W-1:0] count);
        t_sine_result      res;
        logic              neg;
        logic              sticky;
        logic              capped;
        logic              term_neg;
        logic [63:0]       mag;
        logic [63:0]       sq;
        logic [63:0]       term;
        logic [63:0]       divisor;
        logic [127:0]      scaled;
        logic signed [63:0] acc;
        int                n;
        neg    = angle[ANGLE_W-1];
        mag    = {32'd0, (neg ? (~angle + 32'd1) : angle)};
        sq     = (mag * mag) >> FRAC_BITS;
        term   = mag;
        acc    = '0;
        sticky = 1'b0;
        n      = (count > MAX_TERMS) ? MAX_TERMS : int'(count);
        for (int k = 0; k < n; k++) begin
            capped = 1'b0;
            if (k > 0) begin
                divisor = 64'(2 * k) * 64'(2 * k + 1);
                scaled  = ({64'd0, term} * {64'd0, sq}) >> FRAC_BITS;
                if (scaled[127:63] != '0)
                    term = TERM_CAP;
                else
                    term = scaled[63:0] / divisor;
            end
            if (term >= TERM_CAP) begin
                term   = TERM_CAP;
                capped = 1'b1;
            end
            term_neg = neg ^ k[0];
            if (capped) begin
                acc    = term_neg ? -TERM_CAP : TERM_CAP;
                sticky = 1'b1;
            end else begin
                acc = term_neg ? acc - $signed(term) : acc + $signed(term);
                if (acc > TERM_CAP) begin
                    acc    = TERM_CAP;
                    sticky = 1'b1;
                end else if (acc < -TERM_CAP) begin
                    acc    = -TERM_CAP;
                    sticky = 1'b1;
                end
            end
        end
        res.sat = 1'b0;
        if (sticky || acc > SINE_MAX || acc < SINE_MIN) begin
            acc     = (acc >= 0) ? SINE_MAX : SINE_MIN;
            res.sat = 1'b1;
        end
        res.sine = acc[OUT_W-1:0];
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat
    // was taken, leaving start high so back-to-back beats need no gap.
    task automatic send_angle(input logic [ANGLE_W-1:0] angle, input logic [CNT_W-1:0] count);
        bit taken;
        if (gaps_enabled && $urandom_range(99) < 28) begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_angle      <= angle;
        i_term_count <= count;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (!busy) begin
                taken = 1'b1;
                pending_sines.push_back(series_sum(angle, count));
            end
            @(negedge i_clk);
        end
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        while (pending_sines.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic test_angle_extremes();
        logic [ANGLE_W-1:0] angles[7];
        angles = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   ANGLE_HALF_PI, -ANGLE_HALF_PI};
        foreach (angles[i])
            send_angle(angles[i], 4'(MAX_TERMS));
        send_angle(32'h7FFF_FFFF, 4'd1);
        send_angle(32'h8000_0000, 4'd1);
    endtask

    task automatic test_zero_count();
        send_angle(32'h7FFF_FFFF, 4'd0);
        send_angle(32'h8000_0000, 4'd0);
    endtask

    // Counts above the series limit are treated as the limit.
    task automatic test_count_clamp();
        for (int c = MAX_TERMS + 1; c < (1 << CNT_W); c++)
            send_angle($urandom, 4'(c));
    endtask

    task automatic test_random_angles();
        logic [ANGLE_W-1:0] angle;
        logic [CNT_W-1:0]   count;
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            gaps_enabled = !(i >= 400 && i < 600);
            if (i == 500)
                wait_for_drain();
            if ($urandom_range(99) < 85)
                angle = $urandom;
            else
                angle = $urandom_range(2 * 843314857) - 843314857;
            if ($urandom_range(99) < 80)
                count = 4'($urandom_range(MAX_TERMS, 1));
            else
                count = 4'($urandom_range((1 << CNT_W) - 1));
            send_angle(angle, count);
        end
        gaps_enabled = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_sine_result want;
        if (i_rst_n && o_valid) begin
            if (pending_sines.size() == 0) begin
                $display("%0t: result beat with no pending sum: sine %0d sat %0b",
                         $time, o_sine_value, o_saturated);
                fail_count++;
            end else begin
                want = pending_sines.pop_front();
                if (o_sine_value !== want.sine) begin
                    $display("%0t: sine_value expected %0d actual %0d",
                             $time, want.sine, o_sine_value);
                    fail_count++;
                end
                if (o_saturated !== want.sat) begin
                    $display("%0t: saturated expected %0b actual %0b",
                             $time, want.sat, o_saturated);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run when no beat moves in either direction for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_angle      = '0;
        i_term_count = '0;
        gaps_enabled = 1'b1;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_angle_extremes();
        test_zero_count();
        test_count_clamp();
        test_random_angles();

        start <= 1'b0;
        while (pending_sines.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/tts_pkg.sv
hw/rtl/tts_divider.sv
hw/rtl/truncated_taylor_sine.sv
verif/tb_top.sv
